// File: rtl/perspective_segment_rasterizer_core_defines.svh
// assertion macros for the perspective segment rasterizer
// used by the checker module, no other dependencies
`ifndef PERSPECTIVE_SEGMENT_RASTERIZER_CORE_DEFINES_SVH
`define PERSPECTIVE_SEGMENT_RASTERIZER_CORE_DEFINES_SVH

// same-cycle implication
`define PSR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/psr_pkg.sv
// shared widths, register indexes and cell rounding helpers
// used by the rasterizer core and its checker, no dependencies
package psr_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int CANVAS_MAX = 64;
    localparam int MAX_CELLS  = 64;
    localparam int COORD_W    = 20;
    localparam int PT_W       = COORD_W + 2;
    localparam int VAL_W      = 48;
    localparam int DIV_W      = 40;
    localparam int SQ_W       = 48;
    localparam int MUL_AW     = 33;
    localparam int MUL_BW     = 24;
    localparam int MUL_PW     = MUL_AW + MUL_BW;
    localparam int SPLIT      = 20;
    localparam int IDX_W      = 32;
    localparam int DIM_W      = 7;
    localparam int CELL_W     = 6;
    localparam int CNT_W      = 7;
    localparam int IN_W       = 6 * COORD_W;
    localparam int OUT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 20;
    localparam int FOCAL_W    = 16;

    typedef logic signed [VAL_W-1:0] t_val;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAMERA_X = 3'd0,
        CFG_CAMERA_Y = 3'd1,
        CFG_CAMERA_Z = 3'd2,
        CFG_FOCAL    = 3'd3,
        CFG_CANVAS_W = 3'd4,
        CFG_CANVAS_H = 3'd5
    } t_cfg_idx;

    // magnitude rounded half away from zero to whole cells
    function automatic logic [VAL_W-1:0] cell_mag(input t_val u);
        logic [VAL_W-1:0] m;
        m = u[VAL_W-1] ? VAL_W'(-u) : VAL_W'(u);
        return (m + VAL_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    endfunction

    function automatic logic cell_ok(input t_val u, input logic [DIM_W-1:0] dim);
        logic [VAL_W-1:0] m;
        m = cell_mag(u);
        return (!u[VAL_W-1] || (m == '0)) && (m < VAL_W'(dim));
    endfunction

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] d);
        return (d > DIM_W'(CANVAS_MAX)) ? DIM_W'(CANVAS_MAX) : d;
    endfunction

endpackage

// File: rtl/perspective_segment_rasterizer_core.sv
// perspective segment rasterizer: projects one 3d segment and lists its grid cells
// one shared multiplier, a bit-serial divider and a digit-serial square root under a sequencer
// depends on psr_pkg
// steps: setup cross products, up to 7 divisions, up to two square roots on the far-end push path,
//   the start offsets, then the stepping loop
// one segment in flight: ready again in the same cycle the last result is registered
// results leave at most one per cycle, and only while the sink is ready
// reset is synchronous active low; it clears the sequencer and the output valid flag, and
//   loads the camera, focal and canvas registers with their defaults
module perspective_segment_rasterizer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // start_x, start_y, start_z, delta_x, delta_y, delta_z
    input  logic [psr_pkg::IN_W-1:0]      i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // column, row, zero fill
    output logic [psr_pkg::OUT_W-1:0]     o_m_axis_tdata,
    // cell_valid
    output logic                          o_m_axis_tuser,
    output logic                          o_m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [psr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [psr_pkg::CFG_W-1:0]     i_cfg_data
);
    import psr_pkg::*;

    typedef enum logic [45:0] {
        S_IDLE = 46'd1 << 0,  S_X0   = 46'd1 << 1,  S_X1   = 46'd1 << 2,
        S_X2   = 46'd1 << 3,  S_X3   = 46'd1 << 4,  S_X4   = 46'd1 << 5,
        S_X5   = 46'd1 << 6,  S_X6   = 46'd1 << 7,  S_PS0  = 46'd1 << 8,
        S_PS1  = 46'd1 << 9,  S_PS2  = 46'd1 << 10, S_PS3  = 46'd1 << 11,
        S_PS4  = 46'd1 << 12, S_PE0  = 46'd1 << 13, S_PE1  = 46'd1 << 14,
        S_PE2  = 46'd1 << 15, S_PE3  = 46'd1 << 16, S_PE4  = 46'd1 << 17,
        S_PU0  = 46'd1 << 18, S_PU1  = 46'd1 << 19, S_PU2  = 46'd1 << 20,
        S_PU3  = 46'd1 << 21, S_PU4  = 46'd1 << 22, S_PU5  = 46'd1 << 23,
        S_PU6  = 46'd1 << 24, S_PU7  = 46'd1 << 25, S_PU8  = 46'd1 << 26,
        S_PU9  = 46'd1 << 27, S_PU10 = 46'd1 << 28, S_VEC  = 46'd1 << 29,
        S_VD0  = 46'd1 << 30, S_ST1  = 46'd1 << 31, S_ST2  = 46'd1 << 32,
        S_ST3  = 46'd1 << 33, S_ST4  = 46'd1 << 34, S_M0   = 46'd1 << 35,
        S_M1   = 46'd1 << 36, S_M2   = 46'd1 << 37, S_M3   = 46'd1 << 38,
        S_M4   = 46'd1 << 39, S_M5   = 46'd1 << 40, S_M6   = 46'd1 << 41,
        S_LOOP = 46'd1 << 42, S_FIN  = 46'd1 << 43, S_DIV  = 46'd1 << 44,
        S_SQRT = 46'd1 << 45
    } t_state;

    localparam int DCNT_W = $clog2(DIV_W + 1);
    localparam int SCNT_W = $clog2(SQ_W / 2 + 1);

    // control
    t_state r_state, n_state, r_ret, n_ret;
    logic r_ov, n_ov, r_pv, n_pv;
    logic [CNT_W-1:0] r_n, n_n;
    logic signed [COORD_W-1:0] r_cam_x, r_cam_y, r_cam_z;
    logic [FOCAL_W-1:0] r_focal;
    logic [DIM_W-1:0] r_cw, r_ch;

    // payload
    logic signed [COORD_W-1:0] r_sx, r_sy, r_sz, r_dx, r_dy, r_dz;
    logic signed [COORD_W-1:0] n_sx, n_sy, n_sz, n_dx, n_dy, n_dz;
    logic signed [PT_W-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic signed [PT_W-1:0] n_ax, n_ay, n_az, n_bx, n_by, n_bz;
    logic r_par, n_par, r_xmaj, n_xmaj;
    logic signed [MUL_PW-1:0] r_prod, r_tmp, n_tmp;
    t_val r_srx, r_sry, r_erx, r_ery, n_srx, n_sry, n_erx, n_ery;
    logic signed [PT_W:0] r_px, r_py, n_px, n_py;
    logic [MUL_BW-1:0] r_len, n_len;
    logic [FOCAL_W-1:0] r_rad, n_rad;
    t_val r_vx, r_vy, n_vx, n_vy, r_stx, r_sty, n_stx, n_sty;
    t_val r_bxo, r_byo, n_bxo, n_byo;
    t_val r_a, r_b, r_lo, r_hi, n_a, n_b, n_lo, n_hi;
    t_val r_acc, r_ux, r_uy, n_acc, n_ux, n_uy;
    logic [IDX_W-1:0] r_i, n_i, r_num, n_num;
    logic [CELL_W-1:0] r_pcol, r_prow, n_pcol, n_prow;
    logic [DIV_W-1:0] r_dq, n_dq, r_dden, n_dden;
    logic [DIV_W:0] r_drem, n_drem;
    logic r_dneg, n_dneg;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic [SQ_W-1:0] r_sv, r_sr, r_sbit, n_sv, n_sr, n_sbit;
    logic [SCNT_W-1:0] r_scnt, n_scnt;
    t_val r_res, n_res;
    logic [CELL_W-1:0] r_ocol, r_orow, n_ocol, n_orow;
    logic r_ovld, r_olast, n_ovld, n_olast;

    // shared multiplier
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] mul_p;
    assign mul_p = mul_a * mul_b;

    // canvas geometry
    logic [DIM_W-1:0] w, h;
    t_val ox, oy;
    logic [SQ_W-1:0] r2_sh;
    assign w = sat_dim(r_cw);
    assign h = sat_dim(r_ch);
    assign ox = VAL_W'({w, {(FRAC_BITS - 1){1'b0}}});
    assign oy = VAL_W'({h, {(FRAC_BITS - 1){1'b0}}});
    assign r2_sh = SQ_W'(SQ_W'(w >> 1) * SQ_W'(w >> 1) + SQ_W'(h >> 1) * SQ_W'(h >> 1)
                   + SQ_W'(1)) << (2 * FRAC_BITS);

    // differences
    logic signed [COORD_W:0] vx, vy, vz;
    logic signed [PT_W:0] da_x, da_y, db_x, db_y, za, zb;
    logic signed [PT_W-1:0] ex, ey, ez;
    assign vx = (COORD_W + 1)'(r_cam_x) - (COORD_W + 1)'(r_sx);
    assign vy = (COORD_W + 1)'(r_cam_y) - (COORD_W + 1)'(r_sy);
    assign vz = (COORD_W + 1)'(r_cam_z) - (COORD_W + 1)'(r_sz);
    assign ex = PT_W'(r_sx) + PT_W'(r_dx);
    assign ey = PT_W'(r_sy) + PT_W'(r_dy);
    assign ez = PT_W'(r_sz) + PT_W'(r_dz);
    assign da_x = (PT_W + 1)'(r_ax) - (PT_W + 1)'(r_cam_x);
    assign da_y = (PT_W + 1)'(r_ay) - (PT_W + 1)'(r_cam_y);
    assign db_x = (PT_W + 1)'(r_bx) - (PT_W + 1)'(r_cam_x);
    assign db_y = (PT_W + 1)'(r_by) - (PT_W + 1)'(r_cam_y);
    assign za = (PT_W + 1)'(r_cam_z) - (PT_W + 1)'(r_az);
    assign zb = (PT_W + 1)'(r_cam_z) - (PT_W + 1)'(r_bz);

    // divider step
    logic [DIV_W:0] rem_sh;
    logic rem_ge;
    logic [DIV_W-1:0] quo_fin;
    assign rem_sh = {r_drem[DIV_W-1:0], r_dq[DIV_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_dden};
    assign quo_fin = r_dq;

    // square root step
    logic [SQ_W-1:0] sq_sum;
    assign sq_sum = r_sr + r_sbit;

    // current point
    logic cell_hit, can_push;
    logic [VAL_W-1:0] mx, my;
    assign mx = cell_mag(r_ux);
    assign my = cell_mag(r_uy);
    assign cell_hit = cell_ok(r_ux, w) && cell_ok(r_uy, h);
    assign can_push = !r_ov || i_m_axis_tready;

    // step setup
    t_val vmag_x, vmag_y, vxs, vys;
    logic [VAL_W-1:0] ax_c, ay_c;
    assign vxs = r_erx - r_srx;
    assign vys = r_ery - r_sry;
    assign vmag_x = vxs[VAL_W-1] ? -vxs : vxs;
    assign vmag_y = vys[VAL_W-1] ? -vys : vys;
    assign ax_c = VAL_W'(vmag_x) >> FRAC_BITS;
    assign ay_c = VAL_W'(vmag_y) >> FRAC_BITS;

    t_val bxo_c, byo_c, base_c, st_c, span_c, lo_m_a;
    logic [DIM_W-1:0] dim_c;
    assign bxo_c = r_srx + ox;
    assign byo_c = r_sry + oy;
    assign base_c = r_xmaj ? bxo_c : byo_c;
    assign st_c = r_xmaj ? n_stx_st2 : r_res;
    assign dim_c = r_xmaj ? w : h;
    assign span_c = VAL_W'({(DIM_W + 1)'(dim_c) + (DIM_W + 1)'(1), {FRAC_BITS{1'b0}}});
    assign lo_m_a = r_lo - r_a;

    t_val n_stx_st2;
    assign n_stx_st2 = r_stx;

    // divider and root requests
    logic div_go, sq_go;
    t_val div_num;
    logic [DIV_W-1:0] div_den;
    logic [SQ_W-1:0] sq_val;
    t_state call_ret;
    logic push;
    logic [CELL_W-1:0] push_col, push_row;
    logic push_vld, push_last;

    always_comb begin
        n_state = r_state;  n_ret = r_ret;
        n_pv = r_pv;        n_n = r_n;
        n_sx = r_sx; n_sy = r_sy; n_sz = r_sz; n_dx = r_dx; n_dy = r_dy; n_dz = r_dz;
        n_ax = r_ax; n_ay = r_ay; n_az = r_az; n_bx = r_bx; n_by = r_by; n_bz = r_bz;
        n_par = r_par; n_xmaj = r_xmaj; n_tmp = r_tmp;
        n_srx = r_srx; n_sry = r_sry; n_erx = r_erx; n_ery = r_ery;
        n_px = r_px; n_py = r_py; n_len = r_len; n_rad = r_rad;
        n_vx = r_vx; n_vy = r_vy; n_stx = r_stx; n_sty = r_sty;
        n_bxo = r_bxo; n_byo = r_byo;
        n_a = r_a; n_b = r_b; n_lo = r_lo; n_hi = r_hi;
        n_acc = r_acc; n_ux = r_ux; n_uy = r_uy; n_i = r_i; n_num = r_num;
        n_pcol = r_pcol; n_prow = r_prow;
        n_dq = r_dq; n_dden = r_dden; n_drem = r_drem; n_dneg = r_dneg; n_dcnt = r_dcnt;
        n_sv = r_sv; n_sr = r_sr; n_sbit = r_sbit; n_scnt = r_scnt;
        n_res = r_res;
        mul_a = '0; mul_b = '0;
        div_go = 1'b0; div_num = '0; div_den = '0;
        sq_go = 1'b0; sq_val = '0; call_ret = S_IDLE;
        push = 1'b0; push_col = '0; push_row = '0; push_vld = 1'b0; push_last = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_sx = i_s_axis_tdata[0*COORD_W +: COORD_W];
                    n_sy = i_s_axis_tdata[1*COORD_W +: COORD_W];
                    n_sz = i_s_axis_tdata[2*COORD_W +: COORD_W];
                    n_dx = i_s_axis_tdata[3*COORD_W +: COORD_W];
                    n_dy = i_s_axis_tdata[4*COORD_W +: COORD_W];
                    n_dz = i_s_axis_tdata[5*COORD_W +: COORD_W];
                    n_n = '0;
                    n_pv = 1'b0;
                    n_state = S_X0;
                end
            end
            // cross product of direction and camera offset
            S_X0: begin
                mul_a = MUL_AW'(r_dy); mul_b = MUL_BW'(vz);
                n_state = S_X1;
            end
            S_X1: begin
                n_tmp = r_prod;
                mul_a = MUL_AW'(r_dz); mul_b = MUL_BW'(vy);
                n_state = S_X2;
            end
            S_X2: begin
                n_par = (r_tmp == r_prod);
                mul_a = MUL_AW'(r_dz); mul_b = MUL_BW'(vx);
                n_state = S_X3;
            end
            S_X3: begin
                n_tmp = r_prod;
                mul_a = MUL_AW'(r_dx); mul_b = MUL_BW'(vz);
                n_state = S_X4;
            end
            S_X4: begin
                n_par = r_par && (r_tmp == r_prod);
                mul_a = MUL_AW'(r_dx); mul_b = MUL_BW'(vy);
                n_state = S_X5;
            end
            S_X5: begin
                n_tmp = r_prod;
                mul_a = MUL_AW'(r_dy); mul_b = MUL_BW'(vx);
                n_state = S_X6;
            end
            S_X6: begin
                if (((r_dx == '0) && (r_dy == '0) && (r_dz == '0)) ||
                    (r_par && (r_tmp == r_prod))) begin
                    // plot the start point as is
                    n_ux = VAL_W'(r_sx) + ox;
                    n_uy = VAL_W'(r_sy) + oy;
                    n_i = '0; n_num = IDX_W'(1);
                    n_acc = '0; n_hi = '0; n_b = '0; n_stx = '0; n_sty = '0;
                    n_state = S_LOOP;
                end else if (r_sz >= r_cam_z) begin
                    if (ez >= PT_W'(r_cam_z)) begin
                        n_state = S_FIN;
                    end else begin
                        n_ax = ex; n_ay = ey; n_az = ez;
                        n_bx = PT_W'(r_sx); n_by = PT_W'(r_sy); n_bz = PT_W'(r_sz);
                        n_state = S_PS0;
                    end
                end else begin
                    n_ax = PT_W'(r_sx); n_ay = PT_W'(r_sy); n_az = PT_W'(r_sz);
                    n_bx = ex; n_by = ey; n_bz = ez;
                    n_state = S_PS0;
                end
            end
            // near end projection
            S_PS0: begin
                mul_a = $signed({{(MUL_AW - FOCAL_W){1'b0}}, r_focal}); mul_b = MUL_BW'(da_x);
                n_state = S_PS1;
            end
            S_PS1: begin
                div_go = 1'b0;
                div_num = VAL_W'(r_prod); div_den = DIV_W'(za);
                div_go = 1'b1; call_ret = S_PS2;
            end
            S_PS2: begin
                n_srx = r_res;
                mul_a = $signed({{(MUL_AW - FOCAL_W){1'b0}}, r_focal}); mul_b = MUL_BW'(da_y);
                n_state = S_PS3;
            end
            S_PS3: begin
                div_num = VAL_W'(r_prod); div_den = DIV_W'(za);
                div_go = 1'b1; call_ret = S_PS4;
            end
            S_PS4: begin
                n_sry = r_res;
                n_state = (r_bz >= PT_W'(r_cam_z)) ? S_PU0 : S_PE0;
            end
            // far end projection
            S_PE0: begin
                mul_a = $signed({{(MUL_AW - FOCAL_W){1'b0}}, r_focal}); mul_b = MUL_BW'(db_x);
                n_state = S_PE1;
            end
            S_PE1: begin
                div_num = VAL_W'(r_prod); div_den = DIV_W'(zb);
                div_go = 1'b1; call_ret = S_PE2;
            end
            S_PE2: begin
                n_erx = r_res;
                mul_a = $signed({{(MUL_AW - FOCAL_W){1'b0}}, r_focal}); mul_b = MUL_BW'(db_y);
                n_state = S_PE3;
            end
            S_PE3: begin
                div_num = VAL_W'(r_prod); div_den = DIV_W'(zb);
                div_go = 1'b1; call_ret = S_PE4;
            end
            S_PE4: begin
                n_ery = r_res;
                n_state = S_VEC;
            end
            // far end behind the camera: push outward by the canvas radius
            S_PU0: begin
                n_px = db_x; n_py = db_y;
                n_state = S_PU1;
            end
            S_PU1: begin
                mul_a = MUL_AW'(r_px); mul_b = MUL_BW'(r_px);
                n_state = S_PU2;
            end
            S_PU2: begin
                n_tmp = r_prod;
                mul_a = MUL_AW'(r_py); mul_b = MUL_BW'(r_py);
                n_state = S_PU3;
            end
            S_PU3: begin
                if ((r_tmp + r_prod) == '0) begin
                    n_erx = '0; n_ery = '0;
                    n_state = S_VEC;
                end else begin
                    sq_val = SQ_W'(r_tmp + r_prod);
                    sq_go = 1'b1; call_ret = S_PU4;
                end
            end
            S_PU4: begin
                n_len = MUL_BW'(r_res);
                sq_val = r2_sh;
                sq_go = 1'b1; call_ret = S_PU5;
            end
            S_PU5: begin
                n_rad = FOCAL_W'(r_res);
                n_state = S_PU6;
            end
            S_PU6: begin
                mul_a = $signed({{(MUL_AW - FOCAL_W){1'b0}}, r_rad}); mul_b = MUL_BW'(r_px);
                n_state = S_PU7;
            end
            S_PU7: begin
                div_num = VAL_W'(r_prod); div_den = DIV_W'(r_len);
                div_go = 1'b1; call_ret = S_PU8;
            end
            S_PU8: begin
                n_erx = VAL_W'(r_px) + r_res;
                mul_a = $signed({{(MUL_AW - FOCAL_W){1'b0}}, r_rad}); mul_b = MUL_BW'(r_py);
                n_state = S_PU9;
            end
            S_PU9: begin
                div_num = VAL_W'(r_prod); div_den = DIV_W'(r_len);
                div_go = 1'b1; call_ret = S_PU10;
            end
            S_PU10: begin
                n_ery = VAL_W'(r_py) + r_res;
                n_state = S_VEC;
            end
            // step count and per-step increments
            S_VEC: begin
                n_vx = vxs; n_vy = vys;
                n_xmaj = (ax_c >= ay_c);
                n_num = (ax_c >= ay_c) ? IDX_W'(ax_c) : IDX_W'(ay_c);
                n_state = ((ax_c == '0) && (ay_c == '0)) ? S_FIN : S_VD0;
            end
            S_VD0: begin
                div_num = r_vx; div_den = DIV_W'(r_num);
                div_go = 1'b1; call_ret = S_ST1;
            end
            S_ST1: begin
                n_stx = r_res;
                div_num = r_vy; div_den = DIV_W'(r_num);
                div_go = 1'b1; call_ret = S_ST2;
            end
            S_ST2: begin
                n_sty = r_res;
                n_bxo = bxo_c; n_byo = byo_c;
                if (!st_c[VAL_W-1]) begin
                    n_a = base_c;
                    n_b = (st_c < VAL_W'(1)) ? VAL_W'(1) : st_c;
                    n_lo = -VAL_W'(1 << FRAC_BITS);
                    n_hi = span_c;
                end else begin
                    n_a = -base_c;
                    n_b = -st_c;
                    n_lo = -span_c;
                    n_hi = VAL_W'(1 << FRAC_BITS);
                end
                n_state = S_ST3;
            end
            S_ST3: begin
                if (lo_m_a[VAL_W-1] || (lo_m_a == '0)) begin
                    n_res = '0;
                    n_state = S_ST4;
                end else begin
                    div_num = lo_m_a; div_den = DIV_W'(r_b);
                    div_go = 1'b1; call_ret = S_ST4;
                end
            end
            S_ST4: begin
                if (r_res >= VAL_W'(r_num)) begin
                    n_state = S_FIN;
                end else begin
                    n_i = IDX_W'(r_res);
                    n_state = S_M0;
                end
            end
            // offsets of the first step, products split in two halves
            S_M0: begin
                mul_a = $signed({1'b0, r_i}); mul_b = MUL_BW'(r_b >>> SPLIT);
                n_state = S_M1;
            end
            S_M1: begin
                n_tmp = r_prod;
                mul_a = $signed({1'b0, r_i}); mul_b = $signed(MUL_BW'(r_b[SPLIT-1:0]));
                n_state = S_M2;
            end
            S_M2: begin
                n_acc = r_a + (VAL_W'(r_tmp) <<< SPLIT) + VAL_W'(r_prod);
                mul_a = $signed({1'b0, r_i}); mul_b = MUL_BW'(r_stx >>> SPLIT);
                n_state = S_M3;
            end
            S_M3: begin
                n_tmp = r_prod;
                mul_a = $signed({1'b0, r_i}); mul_b = $signed(MUL_BW'(r_stx[SPLIT-1:0]));
                n_state = S_M4;
            end
            S_M4: begin
                n_ux = r_bxo + (VAL_W'(r_tmp) <<< SPLIT) + VAL_W'(r_prod);
                mul_a = $signed({1'b0, r_i}); mul_b = MUL_BW'(r_sty >>> SPLIT);
                n_state = S_M5;
            end
            S_M5: begin
                n_tmp = r_prod;
                mul_a = $signed({1'b0, r_i}); mul_b = $signed(MUL_BW'(r_sty[SPLIT-1:0]));
                n_state = S_M6;
            end
            S_M6: begin
                n_uy = r_byo + (VAL_W'(r_tmp) <<< SPLIT) + VAL_W'(r_prod);
                n_state = S_LOOP;
            end
            // one point per cycle unless the sink stalls; newest cell waits to learn if it is last
            S_LOOP: begin
                if ((r_i >= r_num) || (r_acc > r_hi) || (r_n == CNT_W'(MAX_CELLS))) begin
                    n_state = S_FIN;
                end else if (!(cell_hit && r_pv && !can_push)) begin
                    if (cell_hit) begin
                        if (r_pv) begin
                            push = 1'b1; push_col = r_pcol; push_row = r_prow;
                            push_vld = 1'b1; push_last = 1'b0;
                        end
                        n_pv = 1'b1;
                        n_pcol = CELL_W'(mx);
                        n_prow = CELL_W'(h - DIM_W'(1) - DIM_W'(my));
                        n_n = r_n + CNT_W'(1);
                    end
                    n_i = r_i + IDX_W'(1);
                    n_acc = r_acc + r_b;
                    n_ux = r_ux + r_stx;
                    n_uy = r_uy + r_sty;
                end
            end
            S_FIN: begin
                if (can_push) begin
                    push = 1'b1;
                    push_col = r_pv ? r_pcol : '0;
                    push_row = r_pv ? r_prow : '0;
                    push_vld = r_pv;
                    push_last = 1'b1;
                    n_pv = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (r_dcnt != '0) begin
                    n_drem = rem_ge ? (rem_sh - {1'b0, r_dden}) : rem_sh;
                    n_dq = {r_dq[DIV_W-2:0], rem_ge};
                    n_dcnt = r_dcnt - DCNT_W'(1);
                end else begin
                    n_res = r_dneg ? -VAL_W'(quo_fin) : VAL_W'(quo_fin);
                    n_state = r_ret;
                end
            end
            S_SQRT: begin
                if (r_scnt != '0) begin
                    if (r_sv >= sq_sum) begin
                        n_sv = r_sv - sq_sum;
                        n_sr = (r_sr >> 1) + r_sbit;
                    end else begin
                        n_sr = r_sr >> 1;
                    end
                    n_sbit = r_sbit >> 2;
                    n_scnt = r_scnt - SCNT_W'(1);
                end else begin
                    n_res = VAL_W'(r_sr);
                    n_state = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (div_go) begin
            n_dq = r_dq;
            n_dq = div_num[VAL_W-1] ? DIV_W'(-div_num) : DIV_W'(div_num);
            n_dneg = div_num[VAL_W-1];
            n_dden = div_den;
            n_drem = '0;
            n_dcnt = DCNT_W'(DIV_W);
            n_ret = call_ret;
            n_state = S_DIV;
        end
        if (sq_go) begin
            n_sv = sq_val;
            n_sr = '0;
            n_sbit = SQ_W'(1) << (SQ_W - 2);
            n_scnt = SCNT_W'(SQ_W / 2);
            n_ret = call_ret;
            n_state = S_SQRT;
        end
    end

    // output register
    always_comb begin
        n_ov = r_ov && !i_m_axis_tready;
        n_ocol = r_ocol; n_orow = r_orow; n_ovld = r_ovld; n_olast = r_olast;
        if (push) begin
            n_ov = 1'b1;
            n_ocol = push_col; n_orow = push_row;
            n_ovld = push_vld; n_olast = push_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
            r_ov <= 1'b0;
            r_pv <= 1'b0;
            r_n <= '0;
            r_cam_x <= '0;
            r_cam_y <= '0;
            r_cam_z <= 20'sd16384;
            r_focal <= 16'd16384;
            r_cw <= 7'd64;
            r_ch <= 7'd40;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            r_ov <= n_ov;
            r_pv <= n_pv;
            r_n <= n_n;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CAMERA_X: r_cam_x <= i_cfg_data;
                    CFG_CAMERA_Y: r_cam_y <= i_cfg_data;
                    CFG_CAMERA_Z: r_cam_z <= i_cfg_data;
                    CFG_FOCAL:    r_focal <= i_cfg_data[FOCAL_W-1:0];
                    CFG_CANVAS_W: r_cw <= i_cfg_data[DIM_W-1:0];
                    CFG_CANVAS_H: r_ch <= i_cfg_data[DIM_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sx <= n_sx; r_sy <= n_sy; r_sz <= n_sz;
        r_dx <= n_dx; r_dy <= n_dy; r_dz <= n_dz;
        r_ax <= n_ax; r_ay <= n_ay; r_az <= n_az;
        r_bx <= n_bx; r_by <= n_by; r_bz <= n_bz;
        r_par <= n_par; r_xmaj <= n_xmaj;
        r_prod <= mul_p; r_tmp <= n_tmp;
        r_srx <= n_srx; r_sry <= n_sry; r_erx <= n_erx; r_ery <= n_ery;
        r_px <= n_px; r_py <= n_py; r_len <= n_len; r_rad <= n_rad;
        r_vx <= n_vx; r_vy <= n_vy; r_stx <= n_stx; r_sty <= n_sty;
        r_bxo <= n_bxo; r_byo <= n_byo;
        r_a <= n_a; r_b <= n_b; r_lo <= n_lo; r_hi <= n_hi;
        r_acc <= n_acc; r_ux <= n_ux; r_uy <= n_uy;
        r_i <= n_i; r_num <= n_num;
        r_pcol <= n_pcol; r_prow <= n_prow;
        r_dq <= n_dq; r_dden <= n_dden; r_drem <= n_drem; r_dneg <= n_dneg;
        r_dcnt <= n_dcnt;
        r_sv <= n_sv; r_sr <= n_sr; r_sbit <= n_sbit; r_scnt <= n_scnt;
        r_res <= n_res;
        r_ocol <= n_ocol; r_orow <= n_orow; r_ovld <= n_ovld; r_olast <= n_olast;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata = {{(OUT_W - 2 * CELL_W){1'b0}}, r_orow, r_ocol};
    assign o_m_axis_tuser = r_ovld;
    assign o_m_axis_tlast = r_olast;

endmodule

// File: rtl/psr_checker.sv
// port-level checks for the perspective segment rasterizer core
// depends on psr_pkg and the assertion macro header; bound to the top level below
`include "perspective_segment_rasterizer_core_defines.svh"

module psr_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_axis_tvalid,
    input logic                      o_s_axis_tready,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [psr_pkg::OUT_W-1:0] o_m_axis_tdata,
    input logic                      o_m_axis_tuser,
    input logic                      o_m_axis_tlast
);
    import psr_pkg::*;

    // a stalled result stays offered
    `PSR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "result dropped while stalled")

    // an empty segment closes its run at once
    `PSR_ASSERT_NOW(a_empty_last, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tlast, "empty marker without last")

    // an empty marker names no cell
    `PSR_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata == '0, "empty marker carries a cell")

    // one segment at a time
    `PSR_ASSERT_NXT(a_busy, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "request taken while busy")

endmodule

bind perspective_segment_rasterizer_core psr_checker u_psr_checker (.*);
